// File: rtl/tsa_pkg.sv
`default_nettype none

package tsa_pkg;

   // Fixed field widths of the request and response.
   localparam int ID_W     = 6;
   localparam int REQ_ID_W = 7;
   localparam int CNT_W    = 7;
   localparam int MAP_W    = 64;
   localparam int EPOCH_W  = 64;

   // Request command codes.
   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   // Slot type codes.
   typedef enum logic {
      KIND_WORKER  = 1'b0,
      KIND_CONTROL = 1'b1
   } kind_type;

   // Response status codes.
   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_NO_FREE = 2'd2,
      STATUS_BAD_ID  = 2'd3
   } status_type;

   // One request.
   typedef struct packed {
      cmd_type               cmd;
      kind_type              slot_kind;
      logic [REQ_ID_W-1:0]   slot_to_free;
   } req_type;

   // One response.
   typedef struct packed {
      status_type            status;
      logic [ID_W-1:0]       slot_id;
      logic [CNT_W-1:0]      total_in_use;
      logic [CNT_W-1:0]      worker_in_use;
      logic [CNT_W-1:0]      control_in_use;
      logic [EPOCH_W-1:0]    change_epoch;
      logic [MAP_W-1:0]      worker_map;
      logic [MAP_W-1:0]      control_map;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/tsa_chan_if.sv
`default_nettype none

// Valid/ready channel carrying one payload word per handshake.
interface tsa_chan_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

// File: rtl/tsa_first_free.sv
`default_nettype none

// Finds the lowest set bit of a vector and returns its index.
module tsa_first_free #(
   parameter int WIDTH = 64
) (
   input  logic [WIDTH-1:0]         free_bits,
   output logic                     found,
   output logic [$clog2(WIDTH)-1:0] index
);

   localparam int IDX_W = $clog2(WIDTH);

   logic [WIDTH-1:0] lowest;

   // Isolate the lowest set bit, then encode the one-hot result.
   always_comb begin
      lowest = free_bits & (~free_bits + WIDTH'(1));
      found  = |free_bits;
      index  = '0;
      for (int i = 0; i < WIDTH; i++) begin
         if (lowest[i]) begin
            index = index | IDX_W'(i);
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/tsa_core.sv
`default_nettype none

// Allocator state and the single-pass update for one request.
module tsa_core import tsa_pkg::*; #(
   parameter int SLOT_COUNT = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    fire,
   input  req_type request,
   output rsp_type result
);

   localparam int              IDX_W = $clog2(SLOT_COUNT);
   localparam logic [CNT_W-1:0] SLOTS = CNT_W'(SLOT_COUNT);

   logic [SLOT_COUNT-1:0] used_ff, used_in;
   logic [SLOT_COUNT-1:0] worker_ff, worker_in;
   logic [SLOT_COUNT-1:0] control_ff, control_in;
   logic [CNT_W-1:0]      total_ff, total_in;
   logic [CNT_W-1:0]      worker_cnt_ff, worker_cnt_in;
   logic [CNT_W-1:0]      control_cnt_ff, control_cnt_in;
   logic [EPOCH_W-1:0]    epoch_ff, epoch_in;

   logic [SLOT_COUNT-1:0] free_bits;
   logic                  found;
   logic [IDX_W-1:0]      free_idx;
   logic [IDX_W-1:0]      req_idx;
   logic [SLOT_COUNT-1:0] bit_sel;
   status_type            status;
   logic [ID_W-1:0]       slot_id;

   assign free_bits = ~used_ff;

   tsa_first_free #(
      .WIDTH (SLOT_COUNT)
   ) u_first_free (
      .free_bits (free_bits),
      .found     (found),
      .index     (free_idx)
   );

   // Next state and response for the request in the input register.
   always_comb begin
      used_in        = used_ff;
      worker_in      = worker_ff;
      control_in     = control_ff;
      total_in       = total_ff;
      worker_cnt_in  = worker_cnt_ff;
      control_cnt_in = control_cnt_ff;
      epoch_in       = epoch_ff;
      status         = STATUS_OK;
      slot_id        = '0;
      bit_sel        = '0;
      req_idx        = request.slot_to_free[IDX_W-1:0];

      if (request.cmd == CMD_ALLOC) begin
         if (total_ff >= SLOTS) begin
            status = STATUS_FULL;
         end else if (!found) begin
            status = STATUS_NO_FREE;
         end else begin
            slot_id  = ID_W'(free_idx);
            bit_sel  = SLOT_COUNT'(1) << free_idx;
            used_in  = used_ff | bit_sel;
            epoch_in = epoch_ff + EPOCH_W'(1);
            total_in = total_ff + CNT_W'(1);
            if (request.slot_kind == KIND_WORKER) begin
               worker_in     = worker_ff | bit_sel;
               worker_cnt_in = worker_cnt_ff + CNT_W'(1);
            end else begin
               control_in     = control_ff | bit_sel;
               control_cnt_in = control_cnt_ff + CNT_W'(1);
            end
         end
      end else begin
         slot_id = request.slot_to_free[ID_W-1:0];
         if (request.slot_to_free >= SLOTS || !used_ff[req_idx]) begin
            status = STATUS_BAD_ID;
         end else begin
            // The slot's type is read back from the type map that holds it.
            bit_sel  = SLOT_COUNT'(1) << req_idx;
            used_in  = used_ff & ~bit_sel;
            epoch_in = epoch_ff + EPOCH_W'(1);
            total_in = total_ff - CNT_W'(1);
            if (control_ff[req_idx]) begin
               control_in     = control_ff & ~bit_sel;
               control_cnt_in = control_cnt_ff - CNT_W'(1);
            end else begin
               worker_in     = worker_ff & ~bit_sel;
               worker_cnt_in = worker_cnt_ff - CNT_W'(1);
            end
         end
      end

      result.status         = status;
      result.slot_id        = slot_id;
      result.total_in_use   = total_in;
      result.worker_in_use  = worker_cnt_in;
      result.control_in_use = control_cnt_in;
      result.change_epoch   = epoch_in;
      result.worker_map     = MAP_W'(worker_in);
      result.control_map    = MAP_W'(control_in);
   end

   // State registers, updated once per processed request.
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff        <= '0;
         worker_ff      <= '0;
         control_ff     <= '0;
         total_ff       <= '0;
         worker_cnt_ff  <= '0;
         control_cnt_ff <= '0;
         epoch_ff       <= '0;
      end else if (fire) begin
         used_ff        <= used_in;
         worker_ff      <= worker_in;
         control_ff     <= control_in;
         total_ff       <= total_in;
         worker_cnt_ff  <= worker_cnt_in;
         control_cnt_ff <= control_cnt_in;
         epoch_ff       <= epoch_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/typed_slot_id_allocator_unit.sv
// Typed slot id allocator.
// Requests arrive on req_chan (valid/ready): cmd selects allocate or free,
// slot_kind gives the type of an allocated slot, slot_to_free names the slot
// to release. Each request yields exactly one response on rsp_chan with the
// status, the slot id, the three in-use counts, the change epoch and the
// worker and control maps as they stand after the request.
// The accepting edge loads the request into the input register; it waits there
// while the lowest-free search and the state update settle, and the response
// register loads the response once that register is free or being read.
// Throughput is one request per cycle while the receiver does not stall; the
// state is updated as a request leaves the input register; the next one sees it.
// Reset clears all maps, counts and the epoch, and empties both registers.
// When the receiver stalls, the response register holds and the input
// register can still take one more request; then req_chan.ready drops.
`default_nettype none

module typed_slot_id_allocator_unit import tsa_pkg::*; #(
   parameter int SLOT_COUNT = 64
) (
   input logic        clock,
   input logic        reset,
   tsa_chan_if.sink   req_chan,
   tsa_chan_if.source rsp_chan
);

   logic    in_valid_ff, in_valid_in;
   req_type in_req_ff, in_req_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_rsp_ff, out_rsp_in;

   logic    advance;
   rsp_type result;

   // The input register moves on when the response register is free or being read.
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   tsa_core #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .fire    (advance),
      .request (in_req_ff),
      .result  (result)
   );

   // Next values of the input and response registers.
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_req_in    = in_req_ff;
      out_valid_in = out_valid_ff;
      out_rsp_in   = out_rsp_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
         in_req_in   = req_chan.payload;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_rsp_in   = result;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Valid flags are reset; payloads are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_req_ff  <= in_req_in;
      out_rsp_ff <= out_rsp_in;
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_rsp_ff;

`ifndef SYNTHESIS
   // The total count always equals the sum of the per-type counts.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.payload.total_in_use ==
         CNT_W'(rsp_chan.payload.worker_in_use + rsp_chan.payload.control_in_use))
      else $error("total count differs from sum of type counts");

   // A slot is never marked with both types.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.payload.worker_map & rsp_chan.payload.control_map) == '0)
      else $error("slot marked as both worker and control");

   // The worker count tracks the worker map.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> $countones(rsp_chan.payload.worker_map) ==
         int'(rsp_chan.payload.worker_in_use))
      else $error("worker count does not match worker map");
`endif

endmodule

`default_nettype wire
